// ----- design/f2d96_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2d96_pkg
// Shared constants, types and tables for the binary32 to 96-bit decimal
// converter.
// ----------------------------------------------------------------------------
package f2d96_pkg;

  localparam int SigDigits = 7;
  localparam int MaxScale  = 28;

  localparam int Bias      = 127;
  localparam int MantW     = 24;
  localparam int ExpOfs    = Bias + MantW - 2;
  localparam int ExpMin    = 33;
  localparam int ExpMax    = 223;
  localparam int ExpW      = 8;

  localparam int Log2Num   = 1233;
  localparam int Log2Shift = 12;

  localparam int PowN      = 32;
  localparam int PowIdxW   = 5;
  localparam int PowW      = 94;
  localparam int DivW      = 74;
  localparam int AccW      = 118;
  localparam int XW        = 102;
  localparam int QW        = 28;
  localparam int NW        = 24;
  localparam int TW        = 6;
  localparam int ProdW     = 98;
  localparam int CoeffW    = 96;

  localparam logic [QW-1:0] QLimit = QW'(2 * 10**SigDigits);
  localparam logic [QW-1:0] QBound = QW'(20 * 10**SigDigits);
  localparam logic [31:0]   Recip10 = 32'hCCCCCCCD;
  localparam int            Recip10Shift = 35;

  typedef struct packed {
    logic          neg;
    logic          zero;
    logic          err;
    logic [TW-1:0] t;
  } meta_t;

  typedef logic [PowN-1:0][PowW-1:0] pow_tab_t;

  function automatic pow_tab_t pow10_tab();
    pow_tab_t     tab;
    logic [PowW-1:0] p;
    tab = '0;
    p   = PowW'(1);
    for (int i = 0; i <= MaxScale; i++) begin
      tab[i] = p;
      p      = PowW'(p * PowW'(10));
    end
    return tab;
  endfunction

  localparam pow_tab_t Pow10Tab = pow10_tab();

endpackage

// ----- design/float_to_decimal96.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_decimal96
// Converts an IEEE binary32 word into a 96-bit decimal: coefficient, scale,
// sign and error flag, rounded half away from zero to seven digits.
//
// The input channel takes float_bits_i with valid_i and answers with
// stall_o; the output channel presents the coefficient halves, scale_o,
// negative_o and error_o with valid_o and takes stall_i from the receiver.
// A word is taken at every clock edge where valid is high and stall is low.
// One word enters per cycle while stall_o is low. The pipeline holds the
// 28-step restoring divider that scales large values down by a power of
// ten, the multiply stages around it and seven trailing-zero strip
// stages. Items are independent, so throughput stays at one word per
// cycle for as long as the receiver keeps stall_i low.
// When the receiver stalls while a result waits at the output, the whole
// pipeline freezes and stall_o rises in the same cycle; nothing is dropped
// or repeated. Reset clears all valid bits, so the block comes out of reset
// empty and ready to take a word at once.
// ----------------------------------------------------------------------------
module float_to_decimal96 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] float_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [63:0] coeff_low_o,
  output logic [31:0] coeff_high_o,
  output logic [4:0]  scale_o,
  output logic        negative_o,
  output logic        error_o
);

  import f2d96_pkg::*;

  localparam int NStg = 4 + (QW + 1) + 1 + (SigDigits + 1) + 3 + 1;

  logic en;

  // decode
  logic [7:0]           ex;
  logic [22:0]          fr;
  int                   ee, dd, tt;
  meta_t                s1_meta_d;
  logic                 s1_v_q;
  meta_t                s1_meta_q;
  logic [MantW-1:0]     s1_mant_q;
  logic [ExpW-1:0]      s1_e_q;
  logic [PowW-1:0]      s1_m_q;
  logic [DivW-1:0]      s1_den_q;
  logic [PowIdxW-1:0]   midx, didx;

  // multiply by 10^t
  logic                 s2_v_q, s3_v_q, s4_v_q;
  meta_t                s2_meta_q, s3_meta_q, s4_meta_q;
  logic [MantW-1:0]     s2_mant_q, s3_mant_q;
  logic [ExpW-1:0]      s2_e_q, s3_e_q, s4_e_q;
  logic [DivW-1:0]      s2_den_q, s3_den_q, s4_den_q;
  logic [61:0]          s2_mh_q;
  logic [29:0]          s3_mh_q;
  logic [AccW-1:0]      s2_acc_q, s3_acc_q, s4_acc_q;
  logic [55:0]          pp2, pp3;
  logic [53:0]          pp4;

  // shift and divide
  logic [127:0]         wide, wide_sh;
  logic [6:0]           shr;
  logic [QW:0]          dv_q;
  logic [XW-1:0]        rem_q  [QW+1];
  logic [DivW-1:0]      den_q  [QW+1];
  logic [QW-1:0]        quo_q  [QW+1];
  meta_t                dmeta_q[QW+1];

  // adjust
  logic                 sa_v_q;
  meta_t                sa_meta_q;
  logic [QW-1:0]        sa_q_q;
  logic [63:0]          sa_prod;
  logic                 sa_big, sa_small;
  meta_t                sa_meta_d;
  logic [QW-1:0]        sa_q_d;

  // round and strip
  logic [SigDigits:0]   sv_q;
  logic [NW-1:0]        sn_q   [SigDigits+1];
  meta_t                smeta_q[SigDigits+1];
  logic [QW:0]          rnd;

  // final multiply
  logic                 f1_v_q, f2_v_q, f3_v_q;
  meta_t                f1_meta_q, f2_meta_q, f3_meta_q;
  logic [NW-1:0]        f1_n_q, f2_n_q;
  logic [41:0]          f1_ph_q;
  logic [9:0]           f2_ph_q;
  logic [ProdW-1:0]     f1_p_q, f2_p_q, f3_p_q;
  logic [PowIdxW-1:0]   kidx;
  logic [DivW-1:0]      pk;
  meta_t                fin_meta;
  logic [55:0]          fp1, fp2;
  logic [33:0]          fp3;

  // output
  logic                 vo_q;
  logic [CoeffW-1:0]    coeff_q;
  logic [4:0]           scale_q;
  logic                 neg_q, err_q;
  logic                 ovf;

  logic [NStg-1:0]      vld_all;

  assign en      = !(vo_q && stall_i);
  assign stall_o = !en;

  // -------------------------------------------------------------- decode
  always_comb begin
    ex  = float_bits_i[30:23];
    fr  = float_bits_i[22:0];
    ee  = int'(ex) - Bias;
    dd  = (ee * Log2Num) >>> Log2Shift;
    tt  = SigDigits - 1 - dd;
    if (tt > MaxScale) tt = MaxScale;
    midx = (tt >= 0) ? PowIdxW'(tt) : '0;
    didx = (tt < 0) ? PowIdxW'(-tt) : '0;
    s1_meta_d.neg  = float_bits_i[31];
    s1_meta_d.zero = (ex == '0) && (fr == '0);
    s1_meta_d.err  = !s1_meta_d.zero &&
                     ((int'(ex) >= ExpMax) || (int'(ex) < ExpMin));
    s1_meta_d.t    = TW'(tt);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_meta_q <= s1_meta_d;
      s1_mant_q <= {1'b1, fr};
      s1_e_q    <= ExpW'(int'(ex) - ExpOfs);
      s1_m_q    <= Pow10Tab[midx];
      s1_den_q  <= Pow10Tab[didx][DivW-1:0];
    end
  end

  // -------------------------------------------------------- multiply
  assign pp2 = 56'(s1_mant_q) * 56'(s1_m_q[31:0]);
  assign pp3 = 56'(s2_mant_q) * 56'(s2_mh_q[31:0]);
  assign pp4 = 54'(s3_mant_q) * 54'(s3_mh_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_meta_q <= s1_meta_q;
      s2_mant_q <= s1_mant_q;
      s2_e_q    <= s1_e_q;
      s2_den_q  <= s1_den_q;
      s2_mh_q   <= s1_m_q[93:32];
      s2_acc_q  <= AccW'(pp2);

      s3_meta_q <= s2_meta_q;
      s3_mant_q <= s2_mant_q;
      s3_e_q    <= s2_e_q;
      s3_den_q  <= s2_den_q;
      s3_mh_q   <= s2_mh_q[61:32];
      s3_acc_q  <= s2_acc_q + (AccW'(pp3) << 32);

      s4_meta_q <= s3_meta_q;
      s4_e_q    <= s3_e_q;
      s4_den_q  <= s3_den_q;
      s4_acc_q  <= s3_acc_q + (AccW'(pp4) << 64);
    end
  end

  // ----------------------------------------------------------- shift
  always_comb begin
    wide = 128'(s4_acc_q);
    shr  = 7'(-s4_e_q);
    if (!s4_e_q[ExpW-1]) begin
      wide_sh = wide << s4_e_q[6:0];
    end else begin
      wide_sh = wide >> shr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0]   <= wide_sh[XW-1:0];
      den_q[0]   <= s4_den_q;
      quo_q[0]   <= '0;
      dmeta_q[0] <= s4_meta_q;
    end
  end

  // --------------------------------------------------------- divide
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int Bit = QW - 1 - j;
    logic [XW:0] diff;

    assign diff = {1'b0, rem_q[j]} - {1'b0, XW'(den_q[j]) << Bit};

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[j+1]   <= diff[XW] ? rem_q[j] : diff[XW-1:0];
        quo_q[j+1]   <= quo_q[j] | (QW'(!diff[XW]) << Bit);
        den_q[j+1]   <= den_q[j];
        dmeta_q[j+1] <= dmeta_q[j];
      end
    end
  end

  // ---------------------------------------------------------- adjust
  always_comb begin
    sa_prod   = 64'(quo_q[QW]) * 64'(Recip10);
    sa_big    = quo_q[QW] >= QLimit;
    sa_small  = (dmeta_q[QW].t == TW'(MaxScale)) && (quo_q[QW] < QW'(2));
    sa_q_d    = sa_big ? QW'(sa_prod >> Recip10Shift) : quo_q[QW];
    sa_meta_d = dmeta_q[QW];
    sa_meta_d.t   = dmeta_q[QW].t - TW'(sa_big);
    sa_meta_d.err = dmeta_q[QW].err || (!dmeta_q[QW].zero && sa_small);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q_q    <= sa_q_d;
      sa_meta_q <= sa_meta_d;
    end
  end

  // ----------------------------------------------------- round, strip
  assign rnd = (QW+1)'(sa_q_q) + (QW+1)'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn_q[0]    <= NW'(rnd >> 1);
      smeta_q[0] <= sa_meta_q;
    end
  end

  for (genvar j = 0; j < SigDigits; j++) begin : g_strip
    logic [63:0]   prod;
    logic [NW-1:0] quo;
    logic [NW-1:0] rem;
    logic          drop;
    meta_t         meta_n;

    always_comb begin
      prod = 64'(sn_q[j]) * 64'(Recip10);
      quo  = NW'(prod >> Recip10Shift);
      rem  = sn_q[j] - NW'(quo * NW'(10));
      drop = !smeta_q[j].t[TW-1] && (smeta_q[j].t != '0) && (rem == '0);
      meta_n   = smeta_q[j];
      meta_n.t = smeta_q[j].t - TW'(drop);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_q[j+1]    <= drop ? quo : sn_q[j];
        smeta_q[j+1] <= meta_n;
      end
    end
  end

  // ------------------------------------------------- final multiply
  always_comb begin
    fin_meta = smeta_q[SigDigits];
    kidx     = fin_meta.t[TW-1] ? PowIdxW'(TW'(0) - fin_meta.t) : '0;
    pk       = Pow10Tab[kidx][DivW-1:0];
  end

  assign fp1 = 56'(sn_q[SigDigits]) * 56'(pk[31:0]);
  assign fp2 = 56'(f1_n_q) * 56'(f1_ph_q[31:0]);
  assign fp3 = 34'(f2_n_q) * 34'(f2_ph_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_meta_q <= fin_meta;
      f1_n_q    <= sn_q[SigDigits];
      f1_ph_q   <= pk[73:32];
      f1_p_q    <= ProdW'(fp1);

      f2_meta_q <= f1_meta_q;
      f2_n_q    <= f1_n_q;
      f2_ph_q   <= f1_ph_q[41:32];
      f2_p_q    <= f1_p_q + (ProdW'(fp2) << 32);

      f3_meta_q <= f2_meta_q;
      f3_p_q    <= f2_p_q + (ProdW'(fp3) << 64);
    end
  end

  // ---------------------------------------------------------- output
  assign ovf = f3_p_q[ProdW-1:CoeffW] != '0;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (f3_meta_q.err || (!f3_meta_q.zero && ovf)) begin
        coeff_q <= '0;
        scale_q <= '0;
        neg_q   <= 1'b0;
        err_q   <= 1'b1;
      end else if (f3_meta_q.zero) begin
        coeff_q <= '0;
        scale_q <= '0;
        neg_q   <= f3_meta_q.neg;
        err_q   <= 1'b0;
      end else begin
        coeff_q <= f3_p_q[CoeffW-1:0];
        scale_q <= f3_meta_q.t[TW-1] ? 5'd0 : f3_meta_q.t[4:0];
        neg_q   <= f3_meta_q.neg;
        err_q   <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------- valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      dv_q   <= '0;
      sa_v_q <= 1'b0;
      sv_q   <= '0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      vo_q   <= 1'b0;
    end else if (en) begin
      s1_v_q <= valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      dv_q   <= {dv_q[QW-1:0], s4_v_q};
      sa_v_q <= dv_q[QW];
      sv_q   <= {sv_q[SigDigits-1:0], sa_v_q};
      f1_v_q <= sv_q[SigDigits];
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      vo_q   <= f3_v_q;
    end
  end

  assign vld_all = {s1_v_q, s2_v_q, s3_v_q, s4_v_q, dv_q, sa_v_q, sv_q,
                    f1_v_q, f2_v_q, f3_v_q, vo_q};

  assign valid_o      = vo_q;
  assign coeff_low_o  = coeff_q[63:0];
  assign coeff_high_o = coeff_q[95:64];
  assign scale_o      = scale_q;
  assign negative_o   = neg_q;
  assign error_o      = err_q;

  // ------------------------------------------------------ assertions
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && error_o |-> coeff_low_o == '0 && coeff_high_o == '0 &&
                           scale_o == '0 && !negative_o)
    else $error("error result carries a payload");

  a_scaled_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !error_o && scale_o != '0 |->
      coeff_high_o == '0 && coeff_low_o <= 64'(10**SigDigits))
    else $error("scaled coefficient exceeds digit count");

  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[QW] && !dmeta_q[QW].err && !dmeta_q[QW].zero |-> quo_q[QW] < QBound)
    else $error("decimal exponent estimate off by more than one");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_all))
    else $error("pipeline moved while stalled");

endmodule
